// File: src/srd_pkg.sv
// Shared constants, codes and types of the SLIP receive deframer.
package srd_pkg;

  // Default sizes
  localparam int BUFFER_DEPTH_DEF = 64;
  localparam int COUNT_WIDTH_DEF  = 16;

  // Port widths
  localparam int MAX_LEN_W = 7;
  localparam int LEN_W     = 6;
  localparam int STAT_W    = 16;

  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RST = 7'd64;

  // SLIP codes
  localparam logic [7:0] CODE_END     = 8'hC0;
  localparam logic [7:0] CODE_ESC     = 8'hDB;
  localparam logic [7:0] CODE_ESC_END = 8'hDC;
  localparam logic [7:0] CODE_ESC_ESC = 8'hDD;

  typedef enum logic [1:0] {
    OP_RX      = 2'd0,
    OP_READ    = 2'd1,
    OP_RELEASE = 2'd2,
    OP_NOP     = 2'd3
  } srd_op_t;

  // Status as seen after the last accepted word
  typedef struct packed {
    logic              frame_ready;
    logic [LEN_W-1:0]  frame_length;
    logic              error_flag;
    logic [STAT_W-1:0] parity_count;
    logic [STAT_W-1:0] framing_count;
    logic [STAT_W-1:0] noise_count;
    logic [STAT_W-1:0] overrun_count;
  } srd_status_t;

endpackage

// File: src/srd_core.sv
// Decoder state, error counters and the two-bank frame memory.
module srd_core #(
  parameter int BUFFER_DEPTH = srd_pkg::BUFFER_DEPTH_DEF,
  parameter int COUNT_WIDTH  = srd_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [srd_pkg::MAX_LEN_W-1:0]  cfg_max_len,
  input  logic                           item_go,
  input  logic [1:0]                     op,
  input  logic [7:0]                     rx_byte,
  input  logic                           parity_error,
  input  logic                           framing_error,
  input  logic                           noise_error,
  input  logic                           overrun_error,
  input  logic [5:0]                     read_index,
  output srd_pkg::srd_status_t           status,
  output logic [7:0]                     rd_data
);

  localparam int IDX_W = $clog2(BUFFER_DEPTH);
  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

  logic [srd_pkg::MAX_LEN_W-1:0] max_len_r;
  logic                          bank_r, bank_nxt;
  logic [CNT_W-1:0]              fill_cnt_r, fill_cnt_nxt;
  logic                          started_r, started_nxt;
  logic                          esc_r, esc_nxt;
  logic                          held_r, held_nxt;
  logic [CNT_W-1:0]              held_len_r, held_len_nxt;
  logic                          sticky_r, sticky_nxt;
  logic [COUNT_WIDTH-1:0]        cnt_r   [4];
  logic [COUNT_WIDTH-1:0]        cnt_nxt [4];
  logic                          rd_hit_r;
  logic [7:0]                    mem_q_r;

  logic [7:0] mem [2][BUFFER_DEPTH];

  srd_pkg::srd_op_t op_e;
  logic             wr_en;
  logic [7:0]       wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_idx;
  logic             limit_ok;
  logic             fill_nz;
  logic             is_end;

  assign op_e     = srd_pkg::srd_op_t'(op);
  assign rd_idx   = IDX_W'(read_index);
  assign limit_ok = (32'(fill_cnt_r) < 32'(max_len_r)) &&
                    (32'(fill_cnt_r) < 32'(BUFFER_DEPTH));
  assign fill_nz  = (fill_cnt_r != '0);
  assign is_end   = (rx_byte == srd_pkg::CODE_END);

  always_comb begin
    bank_nxt     = bank_r;
    fill_cnt_nxt = fill_cnt_r;
    started_nxt  = started_r;
    esc_nxt      = esc_r;
    held_nxt     = held_r;
    held_len_nxt = held_len_r;
    sticky_nxt   = sticky_r;
    for (int k = 0; k < 4; k++) cnt_nxt[k] = cnt_r[k];
    wr_en   = 1'b0;
    wr_data = rx_byte;
    rd_en   = 1'b0;

    if (item_go) begin
      case (op_e)
        srd_pkg::OP_RX: begin
          if (!(limit_ok && (fill_nz || is_end || started_r))) begin
            // overflow, or a stray byte outside a frame
            fill_cnt_nxt = '0;
            started_nxt  = 1'b0;
            esc_nxt      = 1'b0;
          end else if (esc_r) begin
            if (rx_byte == srd_pkg::CODE_ESC_END) begin
              wr_en   = 1'b1;
              wr_data = srd_pkg::CODE_END;
            end else if (rx_byte == srd_pkg::CODE_ESC_ESC) begin
              wr_en   = 1'b1;
              wr_data = srd_pkg::CODE_ESC;
            end
            esc_nxt = 1'b0;
          end else if (is_end) begin
            if (fill_nz) begin
              if (held_r) begin
                sticky_nxt = 1'b1;
              end else begin
                held_len_nxt = fill_cnt_r;
                held_nxt     = 1'b1;
                bank_nxt     = ~bank_r;
              end
              fill_cnt_nxt = '0;
              started_nxt  = 1'b0;
            end else begin
              started_nxt = 1'b1;
            end
          end else if (rx_byte == srd_pkg::CODE_ESC) begin
            if (started_r) esc_nxt = 1'b1;
          end else if (started_r) begin
            wr_en = 1'b1;
          end
          if (wr_en) fill_cnt_nxt = fill_cnt_r + CNT_W'(1);

          // parity over framing over noise; overrun on its own
          if (parity_error) begin
            sticky_nxt = 1'b1;
            cnt_nxt[0] = cnt_r[0] + COUNT_WIDTH'(1);
          end else if (framing_error) begin
            sticky_nxt = 1'b1;
            cnt_nxt[1] = cnt_r[1] + COUNT_WIDTH'(1);
          end else if (noise_error) begin
            sticky_nxt = 1'b1;
            cnt_nxt[2] = cnt_r[2] + COUNT_WIDTH'(1);
          end
          if (overrun_error) begin
            sticky_nxt = 1'b1;
            cnt_nxt[3] = cnt_r[3] + COUNT_WIDTH'(1);
          end
        end
        srd_pkg::OP_READ: begin
          rd_en = held_r && (32'(read_index) < 32'(held_len_r)) &&
                  (32'(read_index) < 32'(BUFFER_DEPTH));
        end
        srd_pkg::OP_RELEASE: begin
          held_nxt     = 1'b0;
          held_len_nxt = '0;
          sticky_nxt   = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r  <= srd_pkg::MAX_LEN_RST;
      bank_r     <= 1'b0;
      fill_cnt_r <= '0;
      started_r  <= 1'b0;
      esc_r      <= 1'b0;
      held_r     <= 1'b0;
      held_len_r <= '0;
      sticky_r   <= 1'b0;
      for (int k = 0; k < 4; k++) cnt_r[k] <= '0;
      rd_hit_r   <= 1'b0;
    end else begin
      if (cfg_we) max_len_r <= cfg_max_len;
      bank_r     <= bank_nxt;
      fill_cnt_r <= fill_cnt_nxt;
      started_r  <= started_nxt;
      esc_r      <= esc_nxt;
      held_r     <= held_nxt;
      held_len_r <= held_len_nxt;
      sticky_r   <= sticky_nxt;
      for (int k = 0; k < 4; k++) cnt_r[k] <= cnt_nxt[k];
      if (item_go) rd_hit_r <= rd_en;
    end
  end

  // Fill bank is written, the other bank holds the frame being read.
  // Read data stays put until the next read, so it survives a stall.
  always_ff @(posedge clk) begin
    if (wr_en) mem[bank_r][fill_cnt_r[IDX_W-1:0]] <= wr_data;
    if (rd_en) mem_q_r <= mem[~bank_r][rd_idx];
  end

  assign rd_data = rd_hit_r ? mem_q_r : 8'd0;

  assign status.frame_ready   = held_r;
  assign status.frame_length  = srd_pkg::LEN_W'(held_len_r);
  assign status.error_flag    = sticky_r;
  assign status.parity_count  = srd_pkg::STAT_W'(cnt_r[0]);
  assign status.framing_count = srd_pkg::STAT_W'(cnt_r[1]);
  assign status.noise_count   = srd_pkg::STAT_W'(cnt_r[2]);
  assign status.overrun_count = srd_pkg::STAT_W'(cnt_r[3]);

endmodule

// File: src/slip_receive_deframer.sv
// Top level of the SLIP receive deframer: handshakes and result register.
//
//  channel | handshake        | payload
//  --------+------------------+--------------------------------------------
//  in_     | in_valid/in_stall| op, rx_byte, four line error flags, read_index
//  out_    | out_valid/stall  | read_data, frame status, four error counts
//  cfg_    | cfg_valid/ready  | max_frame_len
//
// One word per cycle in unless out_ stalls, one result per word out; a word's
// state update and bank read are registered on accept, then its result moves
// to the result register. The bank memory's registered read port sets the middle stage.
// Reset is synchronous: state, counters and max_frame_len (64) clear at once.
// A stall on out_ backs up through the middle stage to in_stall.
module slip_receive_deframer #(
  parameter int BUFFER_DEPTH = srd_pkg::BUFFER_DEPTH_DEF,
  parameter int COUNT_WIDTH  = srd_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [srd_pkg::MAX_LEN_W-1:0] cfg_max_frame_len,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_op,
  input  logic [7:0]                    in_rx_byte,
  input  logic                          in_parity_error,
  input  logic                          in_framing_error,
  input  logic                          in_noise_error,
  input  logic                          in_overrun_error,
  input  logic [5:0]                    in_read_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_read_data,
  output logic                          out_frame_ready,
  output logic [srd_pkg::LEN_W-1:0]     out_frame_length,
  output logic                          out_error_flag,
  output logic [srd_pkg::STAT_W-1:0]    out_parity_count,
  output logic [srd_pkg::STAT_W-1:0]    out_framing_count,
  output logic [srd_pkg::STAT_W-1:0]    out_noise_count,
  output logic [srd_pkg::STAT_W-1:0]    out_overrun_count
);

  logic                 go;
  logic                 s1_valid_r, s1_valid_nxt;
  logic                 s1_adv;
  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           rd_data;
  srd_pkg::srd_status_t status;
  srd_pkg::srd_status_t out_status_r;
  logic [7:0]           out_rd_r;

  assign cfg_ready = rst_n;
  assign s1_adv    = !out_valid_r || !out_stall;
  assign in_stall  = !rst_n || (s1_valid_r && !s1_adv);
  assign go        = in_valid && !in_stall;

  srd_core #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_max_len   (cfg_max_frame_len),
    .item_go       (go),
    .op            (in_op),
    .rx_byte       (in_rx_byte),
    .parity_error  (in_parity_error),
    .framing_error (in_framing_error),
    .noise_error   (in_noise_error),
    .overrun_error (in_overrun_error),
    .read_index    (in_read_index),
    .status        (status),
    .rd_data       (rd_data)
  );

  // Middle stage owns the word whose state is now in the core.
  assign s1_valid_nxt  = go || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_status_r <= status;
      out_rd_r     <= rd_data;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_read_data     = out_rd_r;
  assign out_frame_ready   = out_status_r.frame_ready;
  assign out_frame_length  = out_status_r.frame_length;
  assign out_error_flag    = out_status_r.error_flag;
  assign out_parity_count  = out_status_r.parity_count;
  assign out_framing_count = out_status_r.framing_count;
  assign out_noise_count   = out_status_r.noise_count;
  assign out_overrun_count = out_status_r.overrun_count;

endmodule

// File: src/srd_checker.sv
// Port-level checks for the SLIP receive deframer and their bind.
module srd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [7:0]                    out_read_data,
  input logic                          out_frame_ready,
  input logic [srd_pkg::LEN_W-1:0]     out_frame_length,
  input logic [srd_pkg::STAT_W-1:0]    out_parity_count
);

  // Result register is empty right after reset
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word present after reset");

  // No held frame means no length
  a_len_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_ready |-> out_frame_length == '0)
    else $error("frame length without held frame");

  // A read can only return data from a held frame
  a_rd_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_ready |-> out_read_data == 8'd0)
    else $error("read data without held frame");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_parity_count))
    else $error("stalled result word changed");

endmodule

bind slip_receive_deframer srd_checker u_srd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_read_data    (out_read_data),
  .out_frame_ready  (out_frame_ready),
  .out_frame_length (out_frame_length),
  .out_parity_count (out_parity_count)
);
